// ===== design/ctl_pkg.sv =====
// Shared types, constants and helpers for the cache tag lookup block.
package ctl_pkg;

    // Fixed field widths
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned IDX_W    = 15;
    localparam int unsigned LAT_W    = 9;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;

    // Organization
    localparam int unsigned LINE_COUNT_DEF  = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned WAYS            = 4;
    localparam int unsigned WAY_BITS        = 2;

    // Reciprocal scaling used for the index reduction
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned RECIP_W     = 31;

    // Way ages: -1 free, 0 oldest, 3 newest
    localparam logic [2:0] AGE_FREE   = 3'b111;
    localparam logic [2:0] AGE_OLDEST = 3'd0;
    localparam logic [2:0] AGE_NEWEST = 3'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_DIRECT_MODE  = 3'd0;
    localparam logic [2:0] REG_OFFSET_WIDTH = 3'd1;
    localparam logic [2:0] REG_INDEX_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HIT_LATENCY  = 3'd3;
    localparam logic [2:0] REG_MISS_PENALTY = 3'd4;

    typedef struct packed {
        logic       direct_mode;
        logic [4:0] offset_width;
        logic [3:0] index_width;
        logic [7:0] hit_latency;
        logic [7:0] miss_penalty;
    } ctl_cfg_t;

    localparam ctl_cfg_t CFG_RESET = '{
        direct_mode:  1'b0,
        offset_width: 5'd4,
        index_width:  4'd6,
        hit_latency:  8'd1,
        miss_penalty: 8'd100
    };

    // One stored line: valid, age, tag
    typedef struct packed {
        logic        valid;
        logic [2:0]  age;
        logic [31:0] tag;
    } ctl_line_t;

    localparam ctl_line_t LINE_RESET = '{valid: 1'b0, age: AGE_FREE, tag: '0};

    // Bits needed to index n entries, at least one
    function automatic int unsigned ctl_bits(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== design/ctl_ifs.sv =====
// Valid/ready channel interfaces for access requests and lookup results.
interface ctl_req_if import ctl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface ctl_rsp_if import ctl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [LAT_W-1:0] latency;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;

    modport source (output valid, output hit, output latency, output hit_total,
                    output miss_total, input ready);
    modport sink   (input valid, input hit, input latency, input hit_total,
                    input miss_total, output ready);
endinterface

// ===== design/cache_tag_lookup_lru.sv =====
// Top level of the cache tag lookup: register port, front end, queue, lookup engine.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    address[31:0]
//   rsp      out  valid/ready    hit, latency[8:0], hit_total[31:0], miss_total[31:0]
//   apb      in   psel/penable   paddr[4:0], pwdata/prdata[31:0], pready tied high
//
// The front end takes one beat per cycle, unless the queue is full, into a
// three-stage split and index reduction pipe, then a short queue. The lookup
// engine handles each access as a bank read, then a compare and write-back,
// and takes no new access until that one is done. After reset the engine clears
// all ceil(LINE_COUNT / 4) bank rows (64 by default); requests queue up meanwhile.
// A stalled rsp holds the engine; the front keeps accepting until the queue fills.
module cache_tag_lookup_lru import ctl_pkg::*; #(
    parameter int unsigned LINE_COUNT  = LINE_COUNT_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    ctl_req_if.sink            req,
    ctl_rsp_if.source          rsp
);

    localparam int unsigned LW = ctl_bits(LINE_COUNT);
    localparam int unsigned SW = ctl_bits(LINE_COUNT / WAYS);
    localparam int unsigned QW = ADDR_W + LW + SW;

    ctl_cfg_t          cfg_reg;
    logic [2:0]        reg_sel;

    logic              f_valid, f_ready;
    logic [ADDR_W-1:0] f_tag;
    logic [LW-1:0]     f_line;
    logic [SW-1:0]     f_set;
    logic              b_valid, b_ready;
    logic [QW-1:0]     b_data;
    logic [ADDR_W-1:0] b_tag;
    logic [LW-1:0]     b_line;
    logic [SW-1:0]     b_set;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_DIRECT_MODE:  cfg_reg.direct_mode  <= pwdata[0];
                REG_OFFSET_WIDTH: cfg_reg.offset_width <= pwdata[4:0];
                REG_INDEX_WIDTH:  cfg_reg.index_width  <= pwdata[3:0];
                REG_HIT_LATENCY:  cfg_reg.hit_latency  <= pwdata[7:0];
                REG_MISS_PENALTY: cfg_reg.miss_penalty <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_DIRECT_MODE:  prdata = PDATA_W'(cfg_reg.direct_mode);
            REG_OFFSET_WIDTH: prdata = PDATA_W'(cfg_reg.offset_width);
            REG_INDEX_WIDTH:  prdata = PDATA_W'(cfg_reg.index_width);
            REG_HIT_LATENCY:  prdata = PDATA_W'(cfg_reg.hit_latency);
            REG_MISS_PENALTY: prdata = PDATA_W'(cfg_reg.miss_penalty);
            default:          prdata = '0;
        endcase
    end

    ctl_front #(
        .LINE_COUNT (LINE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req        (req),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_tag   (f_tag),
        .push_line  (f_line),
        .push_set   (f_set)
    );

    ctl_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_tag, f_line, f_set}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_tag, b_line, b_set} = b_data;

    ctl_back #(
        .LINE_COUNT (LINE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_tag   (b_tag),
        .pop_line  (b_line),
        .pop_set   (b_set),
        .rsp       (rsp)
    );

endmodule

// ===== design/ctl_front.sv =====
// Front end: splits the address and reduces the index to a line and a set.
module ctl_front import ctl_pkg::*; #(
    parameter int unsigned LINE_COUNT = LINE_COUNT_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ctl_cfg_t                                  cfg,
    ctl_req_if.sink                                   req,
    output logic                                      push_valid,
    input  logic                                      push_ready,
    output logic [ADDR_W-1:0]                         push_tag,
    output logic [ctl_bits(LINE_COUNT)-1:0]           push_line,
    output logic [ctl_bits(LINE_COUNT / WAYS)-1:0]    push_set
);

    localparam int unsigned SETS = LINE_COUNT / WAYS;
    localparam int unsigned LW   = ctl_bits(LINE_COUNT);
    localparam int unsigned SW   = ctl_bits(SETS);
    localparam int unsigned PW   = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_LINE =
        RECIP_W'((64'd1 << RECIP_SHIFT) / LINE_COUNT);
    localparam logic [RECIP_W-1:0] RECIP_SET  =
        RECIP_W'((64'd1 << RECIP_SHIFT) / SETS);

    logic              en;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg, s2_idx_reg;
    logic [ADDR_W-1:0] s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [IDX_W-1:0]  s2_qline_reg, s2_qset_reg;
    logic [IDX_W-1:0]  s3_rline_reg, s3_rset_reg;

    logic [ADDR_W-1:0] ofs_shift;
    logic [5:0]        tag_shift;
    logic [ADDR_W-1:0] tag_calc;
    logic [IDX_W-1:0]  idx_mask;
    logic [IDX_W-1:0]  idx_calc;
    logic [PW-1:0]     prod_line, prod_set;
    logic [31:0]       line_rem, set_rem;

    // Whole pipe moves unless the last stage is blocked by a full queue
    assign en        = !s3_valid_reg || push_ready;
    assign req.ready = en;

    // Address split
    always_comb
    begin
        ofs_shift = req.address >> cfg.offset_width;
        tag_shift = 6'(cfg.offset_width) + 6'(cfg.index_width);
        tag_calc  = (tag_shift >= 6'd32) ? '0 : (req.address >> tag_shift);
        idx_mask  = IDX_W'((16'd1 << cfg.index_width) - 16'd1);
        idx_calc  = IDX_W'(ofs_shift) & idx_mask;
    end

    // Quotient estimates, at most one low
    assign prod_line = PW'(s1_idx_reg) * PW'(RECIP_LINE);
    assign prod_set  = PW'(s1_idx_reg) * PW'(RECIP_SET);

    // Final correction of the remainders
    always_comb
    begin
        line_rem = 32'(s3_rline_reg);
        if (line_rem >= LINE_COUNT)
        begin
            line_rem = line_rem - LINE_COUNT;
        end
        set_rem = 32'(s3_rset_reg);
        if (set_rem >= SETS)
        begin
            set_rem = set_rem - SETS;
        end
    end

    assign push_valid = s3_valid_reg;
    assign push_tag   = s3_tag_reg;
    assign push_line  = LW'(line_rem);
    assign push_set   = SW'(set_rem);

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg   <= idx_calc;
            s1_tag_reg   <= tag_calc;
            s2_idx_reg   <= s1_idx_reg;
            s2_tag_reg   <= s1_tag_reg;
            s2_qline_reg <= IDX_W'(prod_line >> RECIP_SHIFT);
            s2_qset_reg  <= IDX_W'(prod_set >> RECIP_SHIFT);
            s3_tag_reg   <= s2_tag_reg;
            s3_rline_reg <= IDX_W'(32'(s2_idx_reg) - 32'(s2_qline_reg) * LINE_COUNT);
            s3_rset_reg  <= IDX_W'(32'(s2_idx_reg) - 32'(s2_qset_reg) * SETS);
        end
    end

endmodule

// ===== design/ctl_queue.sv =====
// Small FIFO decoupling the front end from the lookup engine.
module ctl_queue import ctl_pkg::*; #(
    parameter int unsigned WIDTH = ADDR_W,
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PW = ctl_bits(DEPTH);
    localparam int unsigned CW = ctl_bits(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/ctl_back.sv =====
// Lookup engine: tag memory banks, compare, fill and LRU age update.
module ctl_back import ctl_pkg::*; #(
    parameter int unsigned LINE_COUNT = LINE_COUNT_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ctl_cfg_t                                  cfg,
    input  logic                                      pop_valid,
    output logic                                      pop_ready,
    input  logic [ADDR_W-1:0]                         pop_tag,
    input  logic [ctl_bits(LINE_COUNT)-1:0]           pop_line,
    input  logic [ctl_bits(LINE_COUNT / WAYS)-1:0]    pop_set,
    ctl_rsp_if.source                                 rsp
);

    localparam int unsigned ROWS = (LINE_COUNT + WAYS - 1) / WAYS;
    localparam int unsigned RW   = ctl_bits(ROWS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [RW-1:0]       clr_row_reg, clr_row_next;
    logic [ADDR_W-1:0]   cur_tag_reg;
    logic [WAY_BITS-1:0] cur_bank_reg;
    logic [RW-1:0]       cur_row_reg;
    logic [CNT_W-1:0]    hit_cnt_reg, miss_cnt_reg;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [LAT_W-1:0]    out_lat_reg;

    logic                rd_en;
    logic [RW-1:0]       rd_row;
    ctl_line_t           rd_data_reg [WAYS];
    logic [WAYS-1:0]     wr_en;
    logic [RW-1:0]       wr_row;
    ctl_line_t           wr_data [WAYS];

    logic                done;
    logic                hit;
    logic [LAT_W-1:0]    lat;
    logic [WAYS-1:0]     match, free_way, old_way;
    logic                found;
    logic [WAY_BITS-1:0] tgt;
    logic [2:0]          pivot;
    ctl_line_t           upd [WAYS];

    // Tag/valid/age banks, one per way; row = set, or line / 4 in direct mode
    for (genvar g = 0; g < WAYS; g++)
    begin : g_bank
        ctl_line_t mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (wr_en[g])
            begin
                mem[wr_row] <= wr_data[g];
            end
            if (rd_en)
            begin
                rd_data_reg[g] <= mem[rd_row];
            end
        end
    end

    assign pop_ready = (state_reg == ST_IDLE);
    assign rd_en     = pop_valid && pop_ready;
    assign rd_row    = cfg.direct_mode ? RW'(32'(pop_line) >> WAY_BITS) : RW'(pop_set);
    assign done      = (state_reg == ST_LOOK) && (!out_valid_reg || rsp.ready);

    // Compare, victim choice and age update
    always_comb
    begin
        found = 1'b0;
        tgt   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w]    = rd_data_reg[w].valid && (rd_data_reg[w].tag == cur_tag_reg);
            free_way[w] = (rd_data_reg[w].age == AGE_FREE);
            old_way[w]  = (rd_data_reg[w].age == AGE_OLDEST);
        end
        // lowest matching way, else first free, else first oldest, else way 0
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && match[w])
            begin
                tgt   = WAY_BITS'(w);
                found = 1'b1;
            end
        end
        hit = cfg.direct_mode ? match[cur_bank_reg] : found;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && free_way[w])
            begin
                tgt   = WAY_BITS'(w);
                found = 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && old_way[w])
            begin
                tgt   = WAY_BITS'(w);
                found = 1'b1;
            end
        end
        pivot = rd_data_reg[tgt].age;

        for (int w = 0; w < WAYS; w++)
        begin
            upd[w] = rd_data_reg[w];
            if (cfg.direct_mode)
            begin
                // direct mode fills the line but leaves ages alone
                if (WAY_BITS'(w) == cur_bank_reg)
                begin
                    upd[w].valid = 1'b1;
                    upd[w].tag   = cur_tag_reg;
                end
            end
            else if (WAY_BITS'(w) == tgt)
            begin
                upd[w].valid = 1'b1;
                upd[w].tag   = cur_tag_reg;
                upd[w].age   = AGE_NEWEST;
            end
            else if ($signed(rd_data_reg[w].age) > $signed(pivot))
            begin
                upd[w].age = rd_data_reg[w].age - 3'd1;
            end
        end

        lat = LAT_W'(cfg.hit_latency) + (hit ? '0 : LAT_W'(cfg.miss_penalty));
    end

    // Bank write port: clearing pass or lookup write-back
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (state_reg == ST_CLEAR)
            begin
                wr_en[w]   = 1'b1;
                wr_data[w] = LINE_RESET;
            end
            else
            begin
                wr_en[w]   = done && (!cfg.direct_mode
                                      || ((WAY_BITS'(w) == cur_bank_reg) && !hit));
                wr_data[w] = upd[w];
            end
        end
        wr_row = (state_reg == ST_CLEAR) ? clr_row_reg : cur_row_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == RW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
                if (hit)
                begin
                    hit_cnt_reg <= hit_cnt_reg + 1'b1;
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Current access and result payload
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_tag_reg  <= pop_tag;
            cur_bank_reg <= pop_line[WAY_BITS-1:0];
            cur_row_reg  <= rd_row;
        end
        if (done)
        begin
            out_hit_reg <= hit;
            out_lat_reg <= lat;
        end
    end

    // Totals change only together with a new result beat
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.latency    = out_lat_reg;
    assign rsp.hit_total  = hit_cnt_reg;
    assign rsp.miss_total = miss_cnt_reg;

endmodule

// ===== verif/cache_tag_lookup_lru_tb.sv =====
// Self-checking testbench for the cache tag lookup with LRU way ages.
`timescale 1ns / 1ps

module cache_tag_lookup_lru_tb import ctl_pkg::*; ();

    localparam int unsigned LINES       = LINE_COUNT_DEF;
    localparam int unsigned SETS        = LINES / WAYS;
    localparam int unsigned NUM_PHASES  = 12;
    localparam int unsigned DRAIN_TAIL  = 24;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic             hit;
        logic [LAT_W-1:0] latency;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
    } lookup_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ctl_req_if access_ch ();
    ctl_rsp_if result_ch ();

    // Shadow cache state and register copy
    logic [31:0]    shadow_tags [LINES];
    logic           shadow_valid [LINES];
    logic [2:0]     shadow_ages [LINES];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    ctl_cfg_t       cfg_model;

    lookup_result_t pending_lookups [$];
    lookup_result_t due;
    bit             mismatch_seen;
    int unsigned    cycle_count;
    int unsigned    burst_left;
    bit             sender_gaps;
    int unsigned    stall_mode;
    int unsigned    mode_timer;
    int unsigned    stall_left;

    cache_tag_lookup_lru DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (access_ch),
        .rsp     (result_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Make a way the newest; ways younger than its old age move down one
    function automatic void touch_way(input int unsigned base, input int unsigned line);
        logic [2:0] pivot;
        pivot = shadow_ages[line];
        for (int unsigned w = 0; w < WAYS; w++)
        begin
            if ($signed(shadow_ages[base + w]) > $signed(pivot))
                shadow_ages[base + w] = shadow_ages[base + w] - 3'd1;
        end
        shadow_ages[line] = AGE_NEWEST;
    endfunction

    // Expected result of one access; updates the shadow state
    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
        lookup_result_t res;
        int unsigned    shift;
        logic [31:0]    index;
        logic [31:0]    tag;
        int unsigned    line;
        int unsigned    base;
        int unsigned    target;
        bit             found;
        bit             hit;
        shift = 32'(cfg_model.offset_width) + 32'(cfg_model.index_width);
        index = addr >> cfg_model.offset_width;
        tag   = (shift >= 32) ? 32'd0 : (addr >> shift);
        index = index & ((32'd1 << cfg_model.index_width) - 32'd1);
        hit   = 1'b0;
        if (cfg_model.direct_mode)
        begin
            line = index % LINES;
            hit  = shadow_valid[line] && (shadow_tags[line] == tag);
            if (!hit)
            begin
                shadow_tags[line]  = tag;
                shadow_valid[line] = 1'b1;
            end
        end
        else
        begin
            base  = (index % SETS) * WAYS;
            found = 1'b0;
            // lowest matching way wins
            for (int unsigned w = 0; w < WAYS; w++)
            begin
                if (!hit && shadow_valid[base + w] && shadow_tags[base + w] == tag)
                begin
                    hit = 1'b1;
                    touch_way(base, base + w);
                end
            end
            if (!hit)
            begin
                target = base;
                for (int unsigned w = 0; w < WAYS; w++)
                begin
                    if (!found && shadow_ages[base + w] == AGE_FREE)
                    begin
                        target = base + w;
                        found  = 1'b1;
                    end
                end
                for (int unsigned w = 0; w < WAYS; w++)
                begin
                    if (!found && shadow_ages[base + w] == AGE_OLDEST)
                    begin
                        target = base + w;
                        found  = 1'b1;
                    end
                end
                shadow_tags[target]  = tag;
                shadow_valid[target] = 1'b1;
                touch_way(base, target);
            end
        end
        if (hit)
        begin
            hit_count   = hit_count + 1;
            res.latency = LAT_W'(cfg_model.hit_latency);
        end
        else
        begin
            miss_count  = miss_count + 1;
            res.latency = LAT_W'(cfg_model.hit_latency) + LAT_W'(cfg_model.miss_penalty);
        end
        res.hit        = hit;
        res.hit_total  = hit_count;
        res.miss_total = miss_count;
        return res;
    endfunction

    // Address built from a small pool of tags and sets, so lines get reused
    function automatic logic [ADDR_W-1:0] make_address();
        longint unsigned tag;
        longint unsigned idx;
        longint unsigned off;
        longint unsigned addr;
        int unsigned     shift;
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        shift = 32'(cfg_model.offset_width) + 32'(cfg_model.index_width);
        tag   = ($urandom_range(0, 9) == 0) ? 64'($urandom()) : 64'($urandom_range(0, 5));
        idx   = ($urandom_range(0, 3) == 0) ? 64'($urandom()) : 64'($urandom_range(0, 3));
        off   = 64'($urandom());
        idx   = idx & ((64'd1 << cfg_model.index_width) - 64'd1);
        off   = off & ((64'd1 << cfg_model.offset_width) - 64'd1);
        addr  = (tag << shift) | (idx << cfg_model.offset_width) | off;
        return addr[ADDR_W-1:0];
    endfunction

    // APB write: setup then access; leaves psel high for a following write
    task automatic write_register(input logic [2:0] reg_index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (reg_index)
            REG_DIRECT_MODE:  cfg_model.direct_mode  = value[0];
            REG_OFFSET_WIDTH: cfg_model.offset_width = value[4:0];
            REG_INDEX_WIDTH:  cfg_model.index_width  = value[3:0];
            REG_HIT_LATENCY:  cfg_model.hit_latency  = value[7:0];
            REG_MISS_PENALTY: cfg_model.miss_penalty = value[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config(input ctl_cfg_t c);
        write_register(REG_DIRECT_MODE, PDATA_W'(c.direct_mode));
        write_register(REG_OFFSET_WIDTH, PDATA_W'(c.offset_width));
        write_register(REG_INDEX_WIDTH, PDATA_W'(c.index_width));
        write_register(REG_HIT_LATENCY, PDATA_W'(c.hit_latency));
        write_register(REG_MISS_PENALTY, PDATA_W'(c.miss_penalty));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // One access beat; bursts of random length with random gaps between when sender_gaps is set
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                access_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        access_ch.valid   <= 1'b1;
        access_ch.address <= addr;
        @(posedge clk);
        while (!access_ch.ready)
            @(posedge clk);
        pending_lookups.push_back(predict_lookup(addr));
        if (sender_gaps)
            burst_left--;
        @(negedge clk);
    endtask

    // Hold off new beats until every expected result is back
    task automatic wait_idle();
        access_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic test_address_extremes();
        apply_config(CFG_RESET);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_000F);
        wait_idle();
    endtask

    // Fill one set, hit in the middle of the age order, then evict three times
    task automatic test_fourway_replacement();
        apply_config('{direct_mode: 1'b0, offset_width: 5'd4, index_width: 4'd6,
                       hit_latency: 8'd3, miss_penalty: 8'd20});
        send_access({22'd1, 6'd5, 4'd0});
        send_access({22'd2, 6'd5, 4'd3});
        send_access({22'd3, 6'd5, 4'd7});
        send_access({22'd4, 6'd5, 4'd9});
        send_access({22'd2, 6'd5, 4'd1});
        send_access({22'd5, 6'd5, 4'd0});
        send_access({22'd1, 6'd5, 4'd0});
        send_access({22'd3, 6'd5, 4'd0});
        wait_idle();
    endtask

    // A direct-mode fill leaves a valid but free way inside a four-way set
    task automatic test_direct_fourway_sharing();
        apply_config('{direct_mode: 1'b0, offset_width: 5'd0, index_width: 4'd8,
                       hit_latency: 8'd2, miss_penalty: 8'd50});
        send_access({24'h000077, 8'h00});
        wait_idle();
        write_register(REG_DIRECT_MODE, 32'd1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        send_access({24'h000077, 8'h01});
        wait_idle();
        write_register(REG_DIRECT_MODE, 32'd0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        // two matching ways: lowest one hits
        send_access({24'h000077, 8'h00});
        // miss takes the valid-but-free way
        send_access({24'h000055, 8'h00});
        // index aliases onto set 0
        send_access({24'h000077, 8'h40});
        wait_idle();
    endtask

    // Index and tag fields running past bit 31, largest latency
    task automatic test_wide_split();
        apply_config('{direct_mode: 1'b1, offset_width: 5'd31, index_width: 4'd15,
                       hit_latency: 8'd255, miss_penalty: 8'd255});
        send_access(32'h8000_0000);
        send_access(32'h7FFF_FFFF);
        send_access(32'hFFFF_FFFF);
        wait_idle();
        apply_config('{direct_mode: 1'b0, offset_width: 5'd24, index_width: 4'd8,
                       hit_latency: 8'd0, miss_penalty: 8'd0});
        send_access(32'hAB00_0000);
        send_access(32'hCD00_0000);
        send_access(32'hAB12_3456);
        wait_idle();
    endtask

    // Random accesses over a sequence of settings, extremes first
    task automatic test_random_phases();
        ctl_cfg_t    c;
        int unsigned count;
        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: c = CFG_RESET;
                1: c = '{direct_mode: 1'b1, offset_width: 5'd0, index_width: 4'd0,
                         hit_latency: 8'd0, miss_penalty: 8'd0};
                2: c = '{direct_mode: 1'b0, offset_width: 5'd16, index_width: 4'd8,
                         hit_latency: 8'd255, miss_penalty: 8'd255};
                3: c = '{direct_mode: 1'b1, offset_width: 5'd5, index_width: 4'd8,
                         hit_latency: 8'd7, miss_penalty: 8'd9};
                4: c = '{direct_mode: 1'b0, offset_width: 5'd31, index_width: 4'd15,
                         hit_latency: 8'd200, miss_penalty: 8'd1};
                default:
                begin
                    c.direct_mode  = 1'($urandom_range(0, 1));
                    c.offset_width = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                                 : 5'($urandom_range(0, 16));
                    c.index_width  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                                 : 4'($urandom_range(0, 8));
                    c.hit_latency  = 8'($urandom());
                    c.miss_penalty = 8'($urandom());
                end
            endcase
            apply_config(c);
            sender_gaps = (p % 3 != 1);
            count       = $urandom_range(100, 140);
            for (int unsigned n = 0; n < count; n++)
            begin
                // stop feeding until the pipe is empty
                if (n == count / 2 && (p == 5 || $urandom_range(0, 2) == 0))
                    wait_idle();
                send_access(make_address());
            end
            wait_idle();
        end
        sender_gaps = 1'b1;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: unexpected result beat hit=%0d latency=%0d", $time,
                         result_ch.hit, result_ch.latency);
                mismatch_seen = 1'b1;
            end
            else
            begin
                due = pending_lookups.pop_front();
                if (result_ch.hit !== due.hit)
                begin
                    $display("%0t: hit expected %0d, got %0d", $time, due.hit, result_ch.hit);
                    mismatch_seen = 1'b1;
                end
                if (result_ch.latency !== due.latency)
                begin
                    $display("%0t: latency expected %0d, got %0d", $time, due.latency,
                             result_ch.latency);
                    mismatch_seen = 1'b1;
                end
                if (result_ch.hit_total !== due.hit_total)
                begin
                    $display("%0t: hit_total expected %0d, got %0d", $time, due.hit_total,
                             result_ch.hit_total);
                    mismatch_seen = 1'b1;
                end
                if (result_ch.miss_total !== due.miss_total)
                begin
                    $display("%0t: miss_total expected %0d, got %0d", $time, due.miss_total,
                             result_ch.miss_total);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Receiver stall pattern: always ready, random, periodic or long stalls
    always @(negedge clk)
    begin
        case (stall_mode)
            0: result_ch.ready <= 1'b1;
            1: result_ch.ready <= ($urandom_range(0, 3) != 0);
            2: result_ch.ready <= ((cycle_count % 7) >= 3);
            default:
            begin
                if (stall_left != 0)
                begin
                    stall_left--;
                    result_ch.ready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(1, 12);
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= 1'b1;
            end
        endcase
        if (mode_timer == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_timer = $urandom_range(50, 400);
        end
        else
            mode_timer--;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        access_ch.valid   = 1'b0;
        access_ch.address = '0;
        result_ch.ready   = 1'b0;
        mismatch_seen     = 1'b0;
        cycle_count       = 0;
        burst_left        = 0;
        sender_gaps       = 1'b1;
        stall_mode        = 0;
        mode_timer        = 0;
        stall_left        = 0;
        for (int unsigned i = 0; i < LINES; i++)
        begin
            shadow_tags[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_ages[i]  = AGE_FREE;
        end
        hit_count  = '0;
        miss_count = '0;
        cfg_model  = CFG_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_address_extremes();
        test_fourway_replacement();
        test_direct_fourway_sharing();
        test_wide_split();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (pending_lookups.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_lookups.size());
            mismatch_seen = 1'b1;
        end
        if (!mismatch_seen)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
